// ===== rtl/core/bsb_pkg.sv =====
package bsb_pkg;

	// fixed-point format of the blend values
	localparam int FRAC_BITS = 16;
	localparam int KW  = 32;                 // knot and parameter width
	localparam int DW  = KW + 1;             // exact difference width
	localparam int VW  = FRAC_BITS + 1;      // blend value width
	localparam int PRW = DW + VW;            // product and quotient width
	localparam int SW  = PRW + 2;            // signed sum of two terms
	localparam logic [VW-1:0] ONE_VAL = VW'(1) << FRAC_BITS;

	// input word kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	// configuration register indexes
	localparam logic REG_DEGREE  = 1'b0;
	localparam logic REG_EPSILON = 1'b1;

	// knot capture targets
	localparam logic [1:0] CAP_K0  = 2'd0;
	localparam logic [1:0] CAP_K1  = 2'd1;
	localparam logic [1:0] CAP_KR  = 2'd2;
	localparam logic [1:0] CAP_KR1 = 2'd3;

	// term selects
	localparam logic TERM_LEFT  = 1'b0;
	localparam logic TERM_RIGHT = 1'b1;

	typedef struct packed {
		logic       knot_we;
		logic       load_in;
		logic       knot_re;
		logic       knot_cap_en;
		logic [1:0] knot_cap;
		logic       val_re;
		logic       val_cap_en;
		logic       val_cap;
		logic       val_we;
		logic       val_wsum;
		logic       term_setup;
		logic       term_sel;
		logic       mul_en;
		logic       div_start;
		logic       acc_en;
		logic       sum_clr;
		logic       res_load;
		logic       res_oor;
	} ctl_cmd_t;

	typedef struct packed {
		logic skip;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/bsb_ctrl.sv =====
module bsb_ctrl import bsb_pkg::*; #(
	parameter int KNOT_COUNT = 16,
	parameter int MAX_DEGREE = 7,
	localparam int KAW = $clog2(KNOT_COUNT),
	localparam int VAW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_cmd,
	input  logic [3:0]     in_index,
	input  logic           cfg_valid,
	input  logic           cfg_index,
	input  logic [2:0]     cfg_degree,
	output ctl_cmd_t       cmd,
	output logic [KAW-1:0] knot_raddr,
	output logic [VAW-1:0] val_addr,
	input  dp_sts_t        sts
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_L0A  = 5'd1;
	localparam logic [4:0] ST_L0B  = 5'd2;
	localparam logic [4:0] ST_L0W  = 5'd3;
	localparam logic [4:0] ST_K0   = 5'd4;
	localparam logic [4:0] ST_K1   = 5'd5;
	localparam logic [4:0] ST_KR   = 5'd6;
	localparam logic [4:0] ST_KR1  = 5'd7;
	localparam logic [4:0] ST_V0   = 5'd8;
	localparam logic [4:0] ST_V1   = 5'd9;
	localparam logic [4:0] ST_VCAP = 5'd10;
	localparam logic [4:0] ST_TSET = 5'd11;
	localparam logic [4:0] ST_TCHK = 5'd12;
	localparam logic [4:0] ST_TDS  = 5'd13;
	localparam logic [4:0] ST_TDW  = 5'd14;
	localparam logic [4:0] ST_WB   = 5'd15;
	localparam logic [4:0] ST_FR   = 5'd16;
	localparam logic [4:0] ST_FC   = 5'd17;

	localparam logic [3:0] MAXD = 4'(MAX_DEGREE);

	logic [4:0] state_q, state_d;
	logic [2:0] degree_q;
	logic [3:0] base_q, p_q, i_q, r_q;
	logic       oor_q, side_q;
	logic [3:0] p_eff;
	logic       oor_eff, fire;
	logic [7:0] k_sum, a_k1, a_kr, a_kr1;
	logic [4:0] i_next;

	assign fire     = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// degree saturated to the supported maximum, table bound check
	assign p_eff   = ({1'b0, degree_q} > MAXD) ? MAXD : {1'b0, degree_q};
	assign oor_eff = ({4'b0, in_index} + {4'b0, p_eff} + 8'd1) > 8'(KNOT_COUNT - 1);

	// knot addresses around the current node
	assign k_sum  = {4'b0, base_q} + {4'b0, i_q};
	assign a_k1   = k_sum + 8'd1;
	assign a_kr   = k_sum + {4'b0, r_q};
	assign a_kr1  = a_kr + 8'd1;
	assign i_next = {1'b0, i_q} + 5'd1;

	// sequencer outputs and next state
	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		knot_raddr = k_sum[KAW-1:0];
		val_addr   = VAW'(i_q);
		cmd.term_sel = side_q;
		cmd.res_oor  = oor_q;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					if (in_cmd == CMD_WRITE) begin
						cmd.knot_we = 1'b1;
					end else begin
						cmd.load_in = 1'b1;
						state_d = oor_eff ? ST_FC : ST_L0A;
					end
				end
			end
			ST_L0A: begin
				cmd.knot_re = 1'b1;
				state_d = ST_L0B;
			end
			ST_L0B: begin
				cmd.knot_cap_en = 1'b1;
				cmd.knot_cap    = CAP_K0;
				cmd.knot_re     = 1'b1;
				knot_raddr      = a_k1[KAW-1:0];
				state_d = ST_L0W;
			end
			ST_L0W: begin
				cmd.val_we = 1'b1;
				if (i_q == p_q) begin
					state_d = (p_q == 4'd0) ? ST_FR : ST_K0;
				end else begin
					state_d = ST_L0A;
				end
			end
			ST_K0: begin
				cmd.knot_re = 1'b1;
				state_d = ST_K1;
			end
			ST_K1: begin
				cmd.knot_cap_en = 1'b1;
				cmd.knot_cap    = CAP_K0;
				cmd.knot_re     = 1'b1;
				knot_raddr      = a_k1[KAW-1:0];
				state_d = ST_KR;
			end
			ST_KR: begin
				cmd.knot_cap_en = 1'b1;
				cmd.knot_cap    = CAP_K1;
				cmd.knot_re     = 1'b1;
				knot_raddr      = a_kr[KAW-1:0];
				state_d = ST_KR1;
			end
			ST_KR1: begin
				cmd.knot_cap_en = 1'b1;
				cmd.knot_cap    = CAP_KR;
				cmd.knot_re     = 1'b1;
				knot_raddr      = a_kr1[KAW-1:0];
				state_d = ST_V0;
			end
			ST_V0: begin
				cmd.knot_cap_en = 1'b1;
				cmd.knot_cap    = CAP_KR1;
				cmd.val_re      = 1'b1;
				state_d = ST_V1;
			end
			ST_V1: begin
				cmd.val_cap_en = 1'b1;
				cmd.val_cap    = TERM_LEFT;
				cmd.val_re     = 1'b1;
				val_addr       = VAW'(i_next);
				state_d = ST_VCAP;
			end
			ST_VCAP: begin
				cmd.val_cap_en = 1'b1;
				cmd.val_cap    = TERM_RIGHT;
				cmd.sum_clr    = 1'b1;
				state_d = ST_TSET;
			end
			ST_TSET: begin
				cmd.term_setup = 1'b1;
				state_d = ST_TCHK;
			end
			ST_TCHK: begin
				if (sts.skip) begin
					state_d = (side_q == TERM_LEFT) ? ST_TSET : ST_WB;
				end else begin
					cmd.mul_en = 1'b1;
					state_d = ST_TDS;
				end
			end
			ST_TDS: begin
				cmd.div_start = 1'b1;
				state_d = ST_TDW;
			end
			ST_TDW: begin
				if (!sts.div_busy) begin
					cmd.acc_en = 1'b1;
					state_d = (side_q == TERM_LEFT) ? ST_TSET : ST_WB;
				end
			end
			ST_WB: begin
				cmd.val_we   = 1'b1;
				cmd.val_wsum = 1'b1;
				if ((i_next + {1'b0, r_q}) > {1'b0, p_q}) begin
					state_d = (r_q == p_q) ? ST_FR : ST_K0;
				end else begin
					state_d = ST_K0;
				end
			end
			ST_FR: begin
				cmd.val_re = 1'b1;
				val_addr   = '0;
				state_d = ST_FC;
			end
			ST_FC: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, loop counters and degree register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			degree_q <= 3'd3;
			base_q   <= '0;
			p_q      <= '0;
			i_q      <= '0;
			r_q      <= '0;
			oor_q    <= 1'b0;
			side_q   <= TERM_LEFT;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_index == REG_DEGREE) begin
				degree_q <= cfg_degree;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_in) begin
						base_q <= in_index;
						p_q    <= p_eff;
						oor_q  <= oor_eff;
						i_q    <= '0;
						r_q    <= '0;
					end
				end
				ST_L0W: begin
					if (i_q == p_q) begin
						i_q <= '0;
						r_q <= 4'd1;
					end else begin
						i_q <= i_next[3:0];
					end
				end
				ST_VCAP: begin
					side_q <= TERM_LEFT;
				end
				ST_TCHK: begin
					if (sts.skip) begin
						side_q <= TERM_RIGHT;
					end
				end
				ST_TDW: begin
					if (!sts.div_busy) begin
						side_q <= TERM_RIGHT;
					end
				end
				ST_WB: begin
					if ((i_next + {1'b0, r_q}) > {1'b0, p_q}) begin
						i_q <= '0;
						r_q <= r_q + 4'd1;
					end else begin
						i_q <= i_next[3:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/bsb_datapath.sv =====
module bsb_datapath import bsb_pkg::*; #(
	parameter int KNOT_COUNT = 16,
	parameter int MAX_DEGREE = 7,
	localparam int KAW = $clog2(KNOT_COUNT),
	localparam int VAW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [3:0]           in_slot,
	input  logic signed [KW-1:0] in_knot,
	input  logic signed [KW-1:0] in_t,
	input  ctl_cmd_t             cmd,
	input  logic [KAW-1:0]       knot_raddr,
	input  logic [VAW-1:0]       val_addr,
	output dp_sts_t              sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VW-1:0]        out_basis,
	output logic                 out_oor
);

	logic signed [KW-1:0] knot_mem [KNOT_COUNT];
	logic [VW-1:0]        val_mem [MAX_DEGREE + 1];

	logic [15:0]          eps_q;
	logic signed [KW-1:0] t_q, knot_rd_q, k0_q, k1_q, kr_q, kr1_q;
	logic [VW-1:0]        val_rd_q, va_q, vb_q, vsel_q, res_q;
	logic [DW-1:0]        num_mag_q, span_mag_q;
	logic                 neg_q, skip_q, oor_q, out_valid_q;
	logic [PRW-1:0]       prod_q, dvd_q;
	logic [DW-1:0]        rem_q;
	logic [5:0]           cnt_q;
	logic signed [SW-1:0] sum_q;

	logic signed [DW-1:0] num, span;
	logic [DW-1:0]        num_mag, span_mag;
	logic [VW-1:0]        vsel, clamped, wdata;
	logic                 hit;
	logic [DW+1:0]        trial;
	logic signed [SW-1:0] term;

	// knot table, registered read
	always_ff @(posedge clk) begin
		if (cmd.knot_we && 32'(in_slot) < KNOT_COUNT) begin
			knot_mem[KAW'(in_slot)] <= in_knot;
		end
		if (cmd.knot_re) begin
			knot_rd_q <= knot_mem[knot_raddr];
		end
	end

	// span threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd7;
		end else if (cfg_valid && cfg_index == REG_EPSILON) begin
			eps_q <= cfg_data;
		end
	end

	// parameter and knot capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			t_q <= in_t;
		end
		if (cmd.knot_cap_en) begin
			case (cmd.knot_cap)
				CAP_K0:  k0_q  <= knot_rd_q;
				CAP_K1:  k1_q  <= knot_rd_q;
				CAP_KR:  kr_q  <= knot_rd_q;
				CAP_KR1: kr1_q <= knot_rd_q;
				default: k0_q  <= knot_rd_q;
			endcase
		end
		if (cmd.val_cap_en) begin
			if (cmd.val_cap == TERM_LEFT) begin
				va_q <= val_rd_q;
			end else begin
				vb_q <= val_rd_q;
			end
		end
	end

	// level-0 span indicator and clamped node sum
	assign hit     = (k0_q <= t_q) && (t_q < knot_rd_q);
	assign clamped = sum_q[SW-1] ? '0 :
		(sum_q > SW'(ONE_VAL)) ? ONE_VAL : sum_q[VW-1:0];
	assign wdata   = cmd.val_wsum ? clamped : (hit ? ONE_VAL : '0);

	// blend value store, registered read
	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			val_mem[val_addr] <= wdata;
		end
		if (cmd.val_re) begin
			val_rd_q <= val_mem[val_addr];
		end
	end

	// term setup: numerator, span, sign and degeneracy
	always_comb begin
		if (cmd.term_sel == TERM_LEFT) begin
			num  = DW'(t_q) - DW'(k0_q);
			span = DW'(kr_q) - DW'(k0_q);
			vsel = va_q;
		end else begin
			num  = DW'(kr1_q) - DW'(t_q);
			span = DW'(kr1_q) - DW'(k1_q);
			vsel = vb_q;
		end
		num_mag  = num[DW-1] ? DW'(-num) : DW'(num);
		span_mag = span[DW-1] ? DW'(-span) : DW'(span);
	end

	always_ff @(posedge clk) begin
		if (cmd.term_setup) begin
			num_mag_q  <= num_mag;
			span_mag_q <= span_mag;
			vsel_q     <= vsel;
			neg_q      <= num[DW-1] ^ span[DW-1];
			skip_q     <= (span_mag == '0) || (span_mag < DW'(eps_q)) || (vsel == '0);
		end
		if (cmd.mul_en) begin
			prod_q <= num_mag_q * vsel_q;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial = {2'b0, rem_q[DW-2:0], dvd_q[PRW-1]} - {2'b0, span_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= 6'(PRW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= prod_q;
		end else if (cnt_q != '0) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				dvd_q <= {dvd_q[PRW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], dvd_q[PRW-1]};
				dvd_q <= {dvd_q[PRW-2:0], 1'b0};
			end
		end
	end

	// signed accumulate of the two terms
	assign term = neg_q ? -SW'(dvd_q) : SW'(dvd_q);

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_q + term;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= cmd.res_oor ? '0 : val_rd_q;
			oor_q <= cmd.res_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_basis    = res_q;
	assign out_oor      = oor_q;
	assign sts.skip     = skip_q;
	assign sts.div_busy = (cnt_q != '0);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/core/bspline_basis_eval_unit.sv =====
// B-spline basis evaluator (Cox-de Boor). A word with tuser 0 writes one
// signed Q16.16 knot into the table and gives no result; a word with
// tuser 1 evaluates N(ctrl_index, degree) at param_t and returns one
// unsigned Q1.16 value, or 0 with out_of_range set when the index runs past
// the table. Every node reads four knots and two values one at a time from
// the tables, and each kept term runs through a single bit-serial divider of
// width PRW = 50 that makes one quotient bit a cycle; terms with a zero
// weight or a degenerate span skip the divider. Configuration writes take
// effect at once.
module bspline_basis_eval_unit import bsb_pkg::*; #(
	parameter int KNOT_COUNT = 16,
	parameter int MAX_DEGREE = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // knot_slot, knot_value, ctrl_index, param_t
	input  logic [0:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // basis_value, zero fill
	output logic [0:0]  m_tuser,   // out_of_range
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int KAW = $clog2(KNOT_COUNT);
	localparam int VAW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;

	ctl_cmd_t       cmd;
	dp_sts_t        sts;
	logic [KAW-1:0] knot_raddr;
	logic [VAW-1:0] val_addr;
	logic [VW-1:0]  basis;

	assign cfg_ready = 1'b1;

	bsb_ctrl #(
		.KNOT_COUNT(KNOT_COUNT),
		.MAX_DEGREE(MAX_DEGREE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[0]),
		.in_index   (s_tdata[39:36]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_degree (cfg_data[2:0]),
		.cmd        (cmd),
		.knot_raddr (knot_raddr),
		.val_addr   (val_addr),
		.sts        (sts)
	);

	bsb_datapath #(
		.KNOT_COUNT(KNOT_COUNT),
		.MAX_DEGREE(MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_slot    (s_tdata[3:0]),
		.in_knot    (s_tdata[35:4]),
		.in_t       (s_tdata[71:40]),
		.cmd        (cmd),
		.knot_raddr (knot_raddr),
		.val_addr   (val_addr),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_basis  (basis),
		.out_oor    (m_tuser[0])
	);

	assign m_tdata = {7'b0, basis};

`ifndef NO_ASSERTIONS
	// divider is never restarted while a quotient is being formed
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	// a result never overwrites one not yet taken
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result register overwritten");

	// an index past the table gives a zero value
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[16:0] == 17'd0))
		else $error("out-of-range result not zero");

	// knot writes only happen from an accepted word
	a_knot_we: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.knot_we |-> (s_tvalid && s_tready))
		else $error("knot write without accepted word");
`endif

endmodule
